@@ hdl/tapvc_pkg.sv @@
package tapvc_pkg;

    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] POS_GAIN_RST = DATA_W'(4575);

    typedef logic signed [DATA_W-1:0] q_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_GAIN_NS = 3'd0,
        REG_FILT_A_NS   = 3'd1,
        REG_FILT_B_NS   = 3'd2,
        REG_ACC_GAIN_NS = 3'd3,
        REG_POS_GAIN_EW = 3'd4,
        REG_FILT_A_EW   = 3'd5,
        REG_FILT_B_EW   = 3'd6,
        REG_ACC_GAIN_EW = 3'd7
    } cfg_idx_t;

    typedef enum logic {
        AXIS_NS = 1'b0,
        AXIS_EW = 1'b1
    } axis_t;

    typedef struct packed {
        q_t pos_gain;
        q_t filt_a;
        q_t filt_b;
        q_t acc_gain;
    } coef_t;

    typedef struct packed {
        logic axis;
        logic enable;
        q_t   pos_target;
        q_t   pos_offset;
        q_t   body_pos;
        q_t   vel_target;
        q_t   vel_offset;
        q_t   velocity;
        q_t   acc_target;
        q_t   acc_measured;
    } item_t;

    // Clamp a sum with two guard bits back to the data range.
    function automatic q_t sat_sum(input logic signed [DATA_W+1:0] v);
        q_t r;
        if (v > $signed({{2{Q_MAX[DATA_W-1]}}, Q_MAX}))
            r = Q_MAX;
        else if (v < $signed({{2{Q_MIN[DATA_W-1]}}, Q_MIN}))
            r = Q_MIN;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W+1:0] ext(input q_t v);
        return {{2{v[DATA_W-1]}}, v};
    endfunction

    // Q16.16 product: round the magnitude half away from zero, apply sign, clamp.
    function automatic q_t mulq(input q_t a, input q_t b);
        logic              neg;
        logic [DATA_W-1:0] ua;
        logic [DATA_W-1:0] ub;
        logic [2*DATA_W-1:0] p;
        logic [2*DATA_W-17:0] m;
        q_t                r;
        neg = a[DATA_W-1] ^ b[DATA_W-1];
        ua  = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
        ub  = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
        p   = {{DATA_W{1'b0}}, ua} * {{DATA_W{1'b0}}, ub};
        p   = p + (2*DATA_W)'(32'h0000_8000);
        m   = p[2*DATA_W-1:16];
        if (neg) begin
            if (m > (2*DATA_W-16)'({1'b1, {(DATA_W-1){1'b0}}}))
                r = Q_MIN;
            else
                r = DATA_W'(-m[DATA_W-1:0]);
        end
        else begin
            if (m > (2*DATA_W-16)'(Q_MAX))
                r = Q_MAX;
            else
                r = m[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/two_axis_position_velocity_controller.sv @@
// Two-axis position/velocity controller. Each item is one control sample for
// the north-south or east-west axis and yields exactly one result: with enable
// set, drive = pos_gain*(pos_target+pos_offset-body_pos) + velocity filter +
// acc_gain*(acc_target-acc_measured), all signed Q16.16 with saturation; with
// enable clear, the axis's last drive is returned and nothing changes. An item
// is taken every cycle while results drain; an accepted item passes the input
// register, then the result register, where its result is offered and held
// while stalled. The per-axis filter state is updated in the same single pass
// that fills the result register. The input stalls only while both registers
// hold items and the result is stalled. Coefficients must be written through
// the cfg port only while the block is idle, which the block does not enforce.
module two_axis_position_velocity_controller
    import tapvc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 axis,
    input  logic                 enable,
    input  logic signed [31:0]   pos_target,
    input  logic signed [31:0]   pos_offset,
    input  logic signed [31:0]   body_pos,
    input  logic signed [31:0]   vel_target,
    input  logic signed [31:0]   vel_offset,
    input  logic signed [31:0]   velocity,
    input  logic signed [31:0]   acc_target,
    input  logic signed [31:0]   acc_measured,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 out_axis,
    output logic signed [31:0]   drive,
    output logic                 updated
);

    coef_t coef_reg [2];
    q_t    vel_filter_reg [2];
    q_t    prev_err_reg [2];
    q_t    last_drive_reg [2];

    logic  s1_valid_reg;
    item_t s1_item_reg;

    logic  out_valid_reg;
    logic  out_axis_reg;
    q_t    drive_reg;
    logic  updated_reg;

    logic  advance;
    logic  in_take;
    coef_t coef;
    q_t    pos_err;
    q_t    vel_err;
    q_t    acc_err;
    q_t    pos_term;
    q_t    acc_term;
    q_t    esum;
    q_t    filt_next;
    q_t    drive_next;

    // Result register frees when empty or taken; the input register is the skid.
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg[AXIS_NS] <= '{pos_gain: POS_GAIN_RST, filt_a: '0, filt_b: '0, acc_gain: '0};
            coef_reg[AXIS_EW] <= '{pos_gain: POS_GAIN_RST, filt_a: '0, filt_b: '0, acc_gain: '0};
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_POS_GAIN_NS: coef_reg[AXIS_NS].pos_gain <= cfg_data;
                REG_FILT_A_NS:   coef_reg[AXIS_NS].filt_a   <= cfg_data;
                REG_FILT_B_NS:   coef_reg[AXIS_NS].filt_b   <= cfg_data;
                REG_ACC_GAIN_NS: coef_reg[AXIS_NS].acc_gain <= cfg_data;
                REG_POS_GAIN_EW: coef_reg[AXIS_EW].pos_gain <= cfg_data;
                REG_FILT_A_EW:   coef_reg[AXIS_EW].filt_a   <= cfg_data;
                REG_FILT_B_EW:   coef_reg[AXIS_EW].filt_b   <= cfg_data;
                REG_ACC_GAIN_EW: coef_reg[AXIS_EW].acc_gain <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= in_take;
        else if (in_take)
            s1_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= '{axis: axis, enable: enable,
                             pos_target: pos_target, pos_offset: pos_offset,
                             body_pos: body_pos, vel_target: vel_target,
                             vel_offset: vel_offset, velocity: velocity,
                             acc_target: acc_target, acc_measured: acc_measured};
        end
    end

    always_comb
    begin
        coef     = coef_reg[s1_item_reg.axis];
        pos_err  = sat_sum(ext(s1_item_reg.pos_target) + ext(s1_item_reg.pos_offset)
                           - ext(s1_item_reg.body_pos));
        vel_err  = sat_sum(ext(s1_item_reg.vel_target) + ext(s1_item_reg.vel_offset)
                           - ext(s1_item_reg.velocity));
        acc_err  = sat_sum(ext(s1_item_reg.acc_target) - ext(s1_item_reg.acc_measured));
        pos_term = mulq(coef.pos_gain, pos_err);
        acc_term = mulq(coef.acc_gain, acc_err);
        esum     = sat_sum(ext(vel_err) + ext(prev_err_reg[s1_item_reg.axis]));
        filt_next = sat_sum(ext(mulq(coef.filt_a, vel_filter_reg[s1_item_reg.axis]))
                            + ext(mulq(coef.filt_b, esum)));
        drive_next = sat_sum(ext(pos_term) + ext(filt_next) + ext(acc_term));
    end

    // Update the axis state as the item moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                vel_filter_reg[i] <= '0;
                prev_err_reg[i]   <= '0;
                last_drive_reg[i] <= '0;
            end
        end
        else if (advance && s1_valid_reg && s1_item_reg.enable)
        begin
            vel_filter_reg[s1_item_reg.axis] <= filt_next;
            prev_err_reg[s1_item_reg.axis]   <= vel_err;
            last_drive_reg[s1_item_reg.axis] <= drive_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_axis_reg <= s1_item_reg.axis;
            updated_reg  <= s1_item_reg.enable;
            drive_reg    <= s1_item_reg.enable ? drive_next
                                               : last_drive_reg[s1_item_reg.axis];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_axis  = out_axis_reg;
    assign drive     = drive_reg;
    assign updated   = updated_reg;

endmodule

@@ hdl/tapvc_checker.sv @@
module tapvc_checker
    import tapvc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              out_axis,
    input logic [DATA_W-1:0] drive,
    input logic              updated
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(drive) && $stable(out_axis)
                                   && $stable(updated))
        else $error("stalled result changed");

    // Input is never stalled while the result slot is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result slot");

    // A fresh result follows an accepted item through the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching item");

    // Input can only stall behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

endmodule

bind two_axis_position_velocity_controller tapvc_checker u_tapvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_axis  (out_axis),
    .drive     (drive),
    .updated   (updated)
);
